[rtl/xorshift128_random_source_macros.svh]
// Assertion macros for the xorshift128 random source.
// Included by the top level; no other dependencies.
`ifndef XORSHIFT128_RANDOM_SOURCE_MACROS_SVH
`define XORSHIFT128_RANDOM_SOURCE_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define XS128_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("xs128 assertion failed");
// Check that a condition never holds
`define XS128_NEVER(lbl, clk, rstn, cond) \
  `XS128_ASSERT(lbl, clk, rstn, !(cond))
`else
`define XS128_ASSERT(lbl, clk, rstn, prop)
`define XS128_NEVER(lbl, clk, rstn, cond)
`endif

`endif

[rtl/xs128_pkg.sv]
// Shared types and constants of the xorshift128 random source.
// No dependencies; imported by every module of the block.
package xs128_pkg;

  // Request codes
  typedef enum logic [1:0] {
    OP_RAW  = 2'd0,
    OP_BND  = 2'd1,
    OP_COIN = 2'd2,
    OP_RNG  = 2'd3
  } op_e;

  // Generator reload values
  localparam logic [31:0] SEED_SUBST = 32'd123456789;
  localparam logic [31:0] INIT_Y     = 32'd362436069;
  localparam logic [31:0] INIT_Z     = 32'd521288629;
  localparam logic [31:0] INIT_W     = 32'd88675123;

  // Range draw resolution
  localparam logic [31:0] RANGE_STEPS = 32'd10000;
  localparam int          STEP_W      = 14;

  // Division by the range steps: multiply by 2^45/10000 rounded up and keep
  // the top 19 bits; exact floor for any 32-bit operand
  localparam logic [31:0] RCP_MUL   = 32'hD1B7_1759;
  localparam int          RCP_SHIFT = 45;
  localparam int          QUO_W     = 19;

  // Step times span remainder, both below 10000
  localparam int          PA_W = 27;

  // Divider geometry
  localparam int          DVD_W      = 32;
  localparam int          DVS_W      = 32;
  localparam int          CNT_W      = 6;
  localparam logic [5:0]  STEPS_WORD = 6'd32;

  // Register map
  localparam int          ADDR_W   = 3;
  localparam logic        REG_SEED = 1'b0;

  // Controller to datapath commands
  typedef struct packed {
    logic cap_in;
    logic adv;
    logic div_ld_word;
    logic div_step;
    logic rcp_word;
    logic rcp_span;
    logic span_split;
    logic mul;
    logic rcp_prod;
    logic out_ld;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_e  op;
    logic bound_pos;
    logic div_last;
  } sts_t;

endpackage

[rtl/xs128_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle while step_i is high.
// Depends on xs128_pkg for widths.
module xs128_div import xs128_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ld_i,
  input  logic [DVD_W-1:0]   dividend_i,
  input  logic [DVS_W-1:0]   divisor_i,
  input  logic [CNT_W-1:0]   steps_i,
  input  logic               step_i,
  output logic [DVS_W-1:0]   rem_o,
  output logic               last_o
);

  logic [DVD_W-1:0] q_q, q_d;
  logic [DVS_W-1:0] r_q, r_d;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W:0]   r_ext;
  logic             ge;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    r_ext = {r_q, q_q[DVD_W-1]};
    ge    = (r_ext >= {1'b0, dvs_q});
    r_d   = r_q;
    q_d   = q_q;
    cnt_d = cnt_q;
    if (ld_i) begin
      r_d   = '0;
      q_d   = dividend_i;
      cnt_d = steps_i;
    end else if (step_i) begin
      r_d   = ge ? DVS_W'(r_ext - {1'b0, dvs_q}) : DVS_W'(r_ext);
      q_d   = {q_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Partial remainder and quotient
  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    q_q <= q_d;
    if (ld_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign rem_o  = r_q;
  assign last_o = (cnt_q == CNT_W'(1));

endmodule

[rtl/xs128_dp.sv]
// Datapath: generator words, seed register, request capture, divider and
// result registers. Depends on xs128_pkg and xs128_div.
module xs128_dp import xs128_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic               seed_we_i,
  input  logic [31:0]        seed_wdata_i,
  output logic [31:0]        seed_o,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] bound_i,
  input  logic signed [31:0] range_low_i,
  input  logic signed [31:0] range_high_i,
  output logic [31:0]        value_o,
  output logic signed [31:0] scaled_o
);

  logic [31:0] seed_q;
  logic [31:0] x_q, y_q, z_q, w_q;
  logic [31:0] t, w_next;
  op_e         op_q;
  logic [31:0] bound_q;
  logic [31:0] lo_q;
  logic [32:0] d_q;
  logic [31:0] absd_q;
  logic        neg_q;
  logic [31:0] value_q;
  logic [31:0] scaled_q;
  logic        bound_pos;

  logic [31:0]       rcp_in;
  logic [63:0]       rcp_full;
  logic [QUO_W-1:0]  rcp_quo;
  logic [QUO_W-1:0]  rq_q;
  logic [31:0]       rem_src;
  logic [31:0]       rem_full;
  logic [STEP_W-1:0] m_q;
  logic [STEP_W-1:0] ar_q;
  logic [QUO_W-1:0]  aq_q;
  logic [PA_W-1:0]   pa_q;
  logic [31:0]       pq_q;
  logic [31:0]       mag_q;

  logic              div_ld;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic [CNT_W-1:0]  div_steps;
  logic [DVS_W-1:0]  div_rem;
  logic              div_last;

  logic [33:0] q_signed;
  logic [33:0] rng_sum;
  logic [31:0] value_d;
  logic [31:0] scaled_d;

  // Seed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (seed_we_i) begin
      seed_q <= seed_wdata_i;
    end
  end

  // Recurrence step
  assign t      = x_q ^ (x_q << 11);
  assign w_next = w_q ^ (w_q >> 19) ^ t ^ (t >> 8);

  // Generator words: reload on seed write, advance on command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= SEED_SUBST;
      y_q <= INIT_Y;
      z_q <= INIT_Z;
      w_q <= INIT_W;
    end else if (seed_we_i) begin
      x_q <= (seed_wdata_i == '0) ? SEED_SUBST : seed_wdata_i;
      y_q <= INIT_Y;
      z_q <= INIT_Z;
      w_q <= INIT_W;
    end else if (cmd_i.adv) begin
      x_q <= y_q;
      y_q <= z_q;
      z_q <= w_q;
      w_q <= w_next;
    end
  end

  // Divide by the range steps through the reciprocal; remainder from the
  // quotient of the previous cycle
  assign rcp_in   = cmd_i.rcp_word ? w_q : (cmd_i.rcp_span ? absd_q : 32'(pa_q));
  assign rcp_full = 64'(rcp_in) * 64'(RCP_MUL);
  assign rcp_quo  = rcp_full[63:RCP_SHIFT];
  assign rem_src  = cmd_i.rcp_span ? w_q : absd_q;
  assign rem_full = rem_src - 32'(rq_q) * RANGE_STEPS;

  // Capture the request, form the range span and scale it in pieces:
  // step * span / steps = step * (span / steps) + step * (span % steps) / steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      op_q    <= op_e'(op_i);
      bound_q <= bound_i;
      lo_q    <= range_low_i;
      d_q     <= {range_high_i[31], range_high_i} - {range_low_i[31], range_low_i};
    end
    if (cmd_i.adv) begin
      neg_q  <= d_q[32];
      absd_q <= d_q[32] ? 32'(-d_q) : d_q[31:0];
    end
    if (cmd_i.rcp_word || cmd_i.rcp_span) begin
      rq_q <= rcp_quo;
    end
    if (cmd_i.rcp_span) begin
      m_q <= rem_full[STEP_W-1:0];
    end
    if (cmd_i.span_split) begin
      aq_q <= rq_q;
      ar_q <= rem_full[STEP_W-1:0];
    end
    if (cmd_i.mul) begin
      pa_q <= PA_W'(m_q) * PA_W'(ar_q);
      pq_q <= 32'(m_q) * 32'(aq_q);
    end
    if (cmd_i.rcp_prod) begin
      mag_q <= pq_q + 32'(rcp_quo);
    end
  end

  assign bound_pos = !bound_q[31] && (bound_q != '0);

  // Divider load: word modulo bound
  assign div_ld    = cmd_i.div_ld_word;
  assign div_dvd   = w_q;
  assign div_dvs   = bound_q;
  assign div_steps = STEPS_WORD;

  xs128_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ld_i       (div_ld),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .steps_i    (div_steps),
    .step_i     (cmd_i.div_step),
    .rem_o      (div_rem),
    .last_o     (div_last)
  );

  // Apply the span sign to the scaled magnitude and offset by the low end
  assign q_signed = neg_q ? 34'(-{2'b00, mag_q}) : {2'b00, mag_q};
  assign rng_sum  = {{2{lo_q[31]}}, lo_q} + q_signed;

  // Select the result by request kind
  always_comb begin
    value_d  = '0;
    scaled_d = '0;
    case (op_q)
      OP_RAW:  value_d = w_q;
      OP_BND:  value_d = bound_pos ? div_rem : '0;
      OP_COIN: value_d = {31'b0, w_q[0]};
      OP_RNG:  scaled_d = rng_sum[31:0];
      default: value_d = '0;
    endcase
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      value_q  <= value_d;
      scaled_q <= scaled_d;
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.bound_pos = bound_pos;
  assign sts_o.div_last  = div_last;
  assign seed_o          = seed_q;
  assign value_o         = value_q;
  assign scaled_o        = scaled_q;

endmodule

[rtl/xs128_ctrl.sv]
// Controller state machine: sequences advance, division, multiply and
// result hand-off. Depends on xs128_pkg.
module xs128_ctrl import xs128_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_ADV  = 10'b00_0000_0010,
    ST_DLD  = 10'b00_0000_0100,
    ST_DIV1 = 10'b00_0000_1000,
    ST_RW   = 10'b00_0001_0000,
    ST_RA   = 10'b00_0010_0000,
    ST_RP   = 10'b00_0100_0000,
    ST_RM   = 10'b00_1000_0000,
    ST_RD   = 10'b01_0000_0000,
    ST_FIN  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = ST_ADV;
        end
      end
      ST_ADV: begin
        if (sts_i.op == OP_BND && !sts_i.bound_pos) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.adv = 1'b1;
          if (sts_i.op == OP_BND) begin
            state_d = ST_DLD;
          end else if (sts_i.op == OP_RNG) begin
            state_d = ST_RW;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_DLD: begin
        cmd_o.div_ld_word = 1'b1;
        state_d           = ST_DIV1;
      end
      ST_DIV1: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      // Quotient of the word by the range steps
      ST_RW: begin
        cmd_o.rcp_word = 1'b1;
        state_d        = ST_RA;
      end
      // Step from the word, quotient of the span
      ST_RA: begin
        cmd_o.rcp_span = 1'b1;
        state_d        = ST_RP;
      end
      // Split the span into quotient and remainder
      ST_RP: begin
        cmd_o.span_split = 1'b1;
        state_d          = ST_RM;
      end
      ST_RM: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_RD;
      end
      ST_RD: begin
        cmd_o.rcp_prod = 1'b1;
        state_d        = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output item flag: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/xorshift128_random_source.sv]
// Top level of the xorshift128 random source: APB seed register,
// controller and datapath. Depends on xs128_pkg, xs128_ctrl, xs128_dp.
//
//   Channel   Handshake                  Payload
//   in        in_valid_i / in_ready_o    op_i, bound_i, range_low_i, range_high_i
//   out       out_valid_o / out_ready_i  value_o, scaled_o
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Raw word, coin and a non-positive bound take the shortest path; a bounded
// draw runs 32 radix-2 divider steps; a range value uses reciprocal
// multiplies by 1/10000 and one product step. The bound divider sets the longest path.
// Reset loads the words from seed 0 at once; no clearing pass.
// A new item is taken while the last result waits in the output register;
// the next result holds in the controller until that register drains.
module xorshift128_random_source import xs128_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] bound_i,
  input  logic signed [31:0] range_low_i,
  input  logic signed [31:0] range_high_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        value_o,
  output logic signed [31:0] scaled_o
);

`include "xorshift128_random_source_macros.svh"

  cmd_t        cmd;
  sts_t        sts;
  logic        seed_we;
  logic [31:0] seed;

  // Register access decode
  assign pready  = 1'b1;
  assign seed_we = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_SEED);
  assign prdata  = (paddr[ADDR_W-1] == REG_SEED) ? seed : '0;

  xs128_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  xs128_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .seed_we_i    (seed_we),
    .seed_wdata_i (pwdata),
    .seed_o       (seed),
    .op_i         (op_i),
    .bound_i      (bound_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .value_o      (value_o),
    .scaled_o     (scaled_o)
  );

  // Busy right after an item is taken
  `XS128_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o)
  // Never load a result over one still waiting
  `XS128_NEVER(a_no_overwrite, clk_i, rst_ni, cmd.out_ld && out_valid_o && !out_ready_i)
  // A result appears only after a load
  `XS128_ASSERT(a_valid_from_load, clk_i, rst_ni, $rose(out_valid_o) |-> $past(cmd.out_ld))

endmodule
